[hw/rtl/htbd_pkg.sv]
package htbd_pkg;

    // table geometry
    localparam int NODE_COUNT    = 512;
    localparam int ADDR_W        = $clog2(NODE_COUNT);
    localparam int IDX_W         = 9;
    localparam int SYM_W         = 8;
    localparam int CFG_W         = 32;
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE);

    // item kinds
    typedef enum logic [0:0] {
        KIND_NODE = 1'b0,
        KIND_BYTE = 1'b1
    } t_kind;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_ROOT_NODE    = 1'b0,
        CFG_SYMBOL_COUNT = 1'b1
    } t_cfg_idx;

    // node table entry
    typedef struct packed {
        logic             is_leaf;
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] one_child;
        logic [IDX_W-1:0] zero_child;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    // input word
    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] node_index;
        logic             node_is_leaf;
        logic [IDX_W-1:0] node_zero_child;
        logic [IDX_W-1:0] node_one_child;
        logic [SYM_W-1:0] node_symbol;
        logic [7:0]       data_byte;
    } t_in_item;

    // output word
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last_of_run;
        logic             all_decoded;
    } t_out_item;

    // table read address source
    typedef enum logic [1:0] {
        RD_NONE  = 2'd0,
        RD_CUR   = 2'd1,
        RD_ROOT  = 2'd2,
        RD_CHILD = 2'd3
    } t_rd_sel;

    // controller to datapath
    typedef struct packed {
        logic    node_wr;
        logic    start;
        t_rd_sel rd_sel;
        logic    step;
        logic    flush;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic rem_zero;
        logic rem_one;
        logic leaf;
        logic last_bit;
        logic pend_valid;
        logic out_free;
    } t_status;

    // node index lies inside the table
    function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
        return int'(idx) < NODE_COUNT;
    endfunction

    // node index to table address
    function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
        return ADDR_W'(idx);
    endfunction

endpackage

[hw/rtl/htbd_ram.sv]
module htbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/htbd_ctrl.sv]
module htbd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  htbd_pkg::t_kind  i_in_kind,
    input  htbd_pkg::t_status i_status,
    output htbd_pkg::t_cmd   o_cmd
);

    import htbd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CUR   = 4'b0010,
        S_CHILD = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   stall;

    // a leaf cannot be taken while the pending symbol has nowhere to go
    assign stall = i_status.leaf && i_status.pend_valid && !i_status.out_free;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_kind == KIND_NODE) begin
                        o_cmd.node_wr = 1'b1;
                    end else if (!i_status.rem_zero) begin
                        o_cmd.start  = 1'b1;
                        o_cmd.rd_sel = RD_CUR;
                        n_state      = S_CUR;
                    end
                end
            end
            S_CUR: begin
                // current entry in hand: fetch the child for this bit
                o_cmd.rd_sel = RD_CHILD;
                n_state      = S_CHILD;
            end
            S_CHILD: begin
                if (!stall) begin
                    o_cmd.step = 1'b1;
                    if (i_status.last_bit || (i_status.leaf && i_status.rem_one)) begin
                        n_state = S_FLUSH;
                    end else if (i_status.leaf) begin
                        o_cmd.rd_sel = RD_ROOT;
                        n_state      = S_CUR;
                    end else begin
                        o_cmd.rd_sel = RD_CHILD;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_status.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/htbd_datapath.sv]
module htbd_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  htbd_pkg::t_in_item              i_in_data,
    input  logic                            i_cfg_we,
    input  htbd_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [htbd_pkg::CFG_W-1:0]      i_cfg_data,
    input  htbd_pkg::t_cmd                  i_cmd,
    output htbd_pkg::t_status               o_status,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output htbd_pkg::t_out_item             o_out_data
);

    import htbd_pkg::*;

    logic [IDX_W-1:0]     r_root, r_cur, n_cur, r_next;
    logic [CFG_W-1:0]     r_rem, n_rem;
    logic [7:0]           r_byte;
    logic [BIT_CNT_W-1:0] r_bit_cnt;
    logic                 r_rd_oob;
    logic                 r_pend_valid;
    logic [SYM_W-1:0]     r_pend_sym;
    logic                 r_pend_all;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [NODE_W-1:0]    ram_rdata;
    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    t_node                wr_node, entry;
    logic [IDX_W-1:0]     rd_idx, child_idx;
    logic                 child_bit, take_leaf, out_load, out_free;

    // node table
    htbd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_node),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // node write; indexes past the table are dropped
    always_comb begin
        wr_node.is_leaf    = i_in_data.node_is_leaf;
        wr_node.symbol     = i_in_data.node_symbol;
        wr_node.one_child  = i_in_data.node_one_child;
        wr_node.zero_child = i_in_data.node_zero_child;
    end
    assign ram_we    = i_cmd.node_wr && idx_ok(i_in_data.node_index);
    assign ram_waddr = to_addr(i_in_data.node_index);

    // entry read back; out of range reads as all zero
    assign entry = r_rd_oob ? '0 : t_node'(ram_rdata);

    // child for the bit in hand (next bit when a step continues the walk)
    assign child_bit = i_cmd.step ? r_byte[6] : r_byte[7];
    assign child_idx = child_bit ? entry.one_child : entry.zero_child;

    // read address select
    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_NONE:  rd_idx = r_cur;
            RD_CUR:   rd_idx = r_cur;
            RD_ROOT:  rd_idx = r_root;
            RD_CHILD: rd_idx = child_idx;
        endcase
    end
    assign ram_re    = (i_cmd.rd_sel != RD_NONE);
    assign ram_raddr = to_addr(rd_idx);

    assign take_leaf = i_cmd.step && entry.is_leaf;
    assign out_free  = !r_out_valid || i_out_ready;
    assign out_load  = (take_leaf && r_pend_valid) || i_cmd.flush;

    // walker position and symbol count
    always_comb begin
        n_cur = r_cur;
        n_rem = r_rem;
        priority if (i_cfg_we && i_cfg_idx == CFG_SYMBOL_COUNT) begin
            n_rem = i_cfg_data;
            n_cur = r_root;
        end else if (take_leaf) begin
            n_rem = r_rem - CFG_W'(1);
            n_cur = r_root;
        end else if (i_cmd.step) begin
            n_cur = r_next;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root       <= '0;
            r_cur        <= '0;
            r_rem        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_ROOT_NODE) begin
                r_root <= i_cfg_data[IDX_W-1:0];
            end
            r_cur <= n_cur;
            r_rem <= n_rem;
            if (take_leaf) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_byte    <= i_in_data.data_byte;
            r_bit_cnt <= BIT_CNT_W'(BITS_PER_BYTE - 1);
        end else if (i_cmd.step) begin
            r_byte    <= {r_byte[6:0], 1'b0};
            r_bit_cnt <= r_bit_cnt - BIT_CNT_W'(1);
        end
        if (i_cmd.rd_sel == RD_CHILD) begin
            r_next <= child_idx;
        end
        if (ram_re) begin
            r_rd_oob <= !idx_ok(rd_idx);
        end
        // the older symbol leaves when a newer one arrives or the walk ends
        if (out_load) begin
            r_out.symbol      <= r_pend_sym;
            r_out.last_of_run <= i_cmd.flush;
            r_out.all_decoded <= r_pend_all;
        end
        if (take_leaf) begin
            r_pend_sym <= entry.symbol;
            r_pend_all <= (r_rem == CFG_W'(1));
        end
    end

    // status back to the controller
    always_comb begin
        o_status.rem_zero   = (r_rem == '0);
        o_status.rem_one    = (r_rem == CFG_W'(1));
        o_status.leaf       = entry.is_leaf;
        o_status.last_bit   = (r_bit_cnt == '0);
        o_status.pend_valid = r_pend_valid;
        o_status.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/huffman_tree_bit_decoder.sv]
// Node write: stored in the table, no result.
// Byte: walked bit by bit from acceptance until the last symbol is in the output register;
// up to 8 bits are walked (fewer if the count runs out), with one root re-read per symbol that
// does not end the walk and one table read per step; the next word is taken after the walk.
// A byte seen with no symbols left is taken with no walk. Output waits stall the walk.
// Synchronous active-low reset clears walker to node 0, root and count to 0, no results.
module huffman_tree_bit_decoder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  htbd_pkg::t_in_item         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output htbd_pkg::t_out_item        o_out_data,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [htbd_pkg::CFG_W-1:0] i_cfg_data
);

    import htbd_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer
    htbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_kind  (i_in_data.kind),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // table, walker and output register
    htbd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (t_cfg_idx'(i_cfg_idx)),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[verif/tb_huffman_tree_bit_decoder.sv]
`timescale 1ns / 1ps

module tb_huffman_tree_bit_decoder;

    import htbd_pkg::*;

    // covers the longest byte walk without output waits; leave some slack
    localparam int DRAIN_CYCLES = 32;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in_item         in_data   = '0;
    logic             out_ready = 1'b0;
    logic             cfg_we    = 1'b0;
    logic             cfg_idx   = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_ready;
    logic             out_valid;
    t_out_item        out_data;

    int tx_idle_pct;
    int rx_idle_pct;
    int mismatch_count = 0;

    // decoder image kept by the testbench
    t_node            node_image [NODE_COUNT];
    bit               node_loaded [NODE_COUNT];
    int               loaded_nodes [$];
    logic [IDX_W-1:0] walk_node;
    logic [IDX_W-1:0] root_reg;
    logic [31:0]      symbols_left;

    t_out_item pending_symbols [$];

    huffman_tree_bit_decoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // receiver back-pressure
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // -------------------------------------------------------------------------
    // prediction
    // -------------------------------------------------------------------------

    // record a node write, or walk the tree for an accepted byte and queue the symbols it yields
    function automatic void walk_tree(input t_in_item w);
        t_node            cur_e;
        t_node            next_e;
        logic [IDX_W-1:0] next_idx;
        t_out_item        sym;
        t_out_item        run [$];
        if (w.kind == KIND_NODE) begin
            node_image[w.node_index].is_leaf    = w.node_is_leaf;
            node_image[w.node_index].symbol     = w.node_symbol;
            node_image[w.node_index].one_child  = w.node_one_child;
            node_image[w.node_index].zero_child = w.node_zero_child;
            if (!node_loaded[w.node_index])
                loaded_nodes.push_back(int'(w.node_index));
            node_loaded[w.node_index] = 1'b1;
            return;
        end
        for (int b = BITS_PER_BYTE - 1; b >= 0; b--) begin
            // padding once the count runs out
            if (symbols_left == 0)
                break;
            cur_e    = node_image[walk_node];
            next_idx = w.data_byte[b] ? cur_e.one_child : cur_e.zero_child;
            next_e   = node_image[next_idx];
            if (next_e.is_leaf) begin
                symbols_left    = symbols_left - 1;
                sym.symbol      = next_e.symbol;
                sym.last_of_run = 1'b0;
                sym.all_decoded = (symbols_left == 0);
                run.push_back(sym);
                walk_node = root_reg;
            end else begin
                walk_node = next_idx;
            end
        end
        if (run.size() > 0)
            run[run.size()-1].last_of_run = 1'b1;
        foreach (run[i])
            pending_symbols.push_back(run[i]);
    endfunction

    function automatic void apply_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        case (idx)
            CFG_ROOT_NODE: begin
                root_reg = val[IDX_W-1:0];
            end
            CFG_SYMBOL_COUNT: begin
                symbols_left = val;
                walk_node    = root_reg;
            end
            default: ;
        endcase
    endfunction

    // -------------------------------------------------------------------------
    // result checking
    // -------------------------------------------------------------------------
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_symbols.size() == 0) begin
                $error("unexpected symbol %0h (last %0b, all %0b)",
                       out_data.symbol, out_data.last_of_run, out_data.all_decoded);
                mismatch_count++;
            end else begin
                want = pending_symbols.pop_front();
                if (out_data.symbol !== want.symbol) begin
                    $error("symbol: expected %0h, got %0h", want.symbol, out_data.symbol);
                    mismatch_count++;
                end
                if (out_data.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0b, got %0b",
                           want.last_of_run, out_data.last_of_run);
                    mismatch_count++;
                end
                if (out_data.all_decoded !== want.all_decoded) begin
                    $error("all_decoded: expected %0b, got %0b",
                           want.all_decoded, out_data.all_decoded);
                    mismatch_count++;
                end
            end
        end
    end

    // -------------------------------------------------------------------------
    // stimulus helpers
    // -------------------------------------------------------------------------

    // present one word and hold it until taken
    task automatic send_word(input t_in_item w);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        walk_tree(w);
    endtask

    // node write; the unused byte field is randomised
    task automatic send_node(input int idx, input bit leaf, input int zc, input int oc,
                             input int sym);
        t_in_item w;
        w.kind            = KIND_NODE;
        w.node_index      = IDX_W'(idx);
        w.node_is_leaf    = leaf;
        w.node_zero_child = IDX_W'(zc);
        w.node_one_child  = IDX_W'(oc);
        w.node_symbol     = SYM_W'(sym);
        w.data_byte       = 8'($urandom_range(255));
        send_word(w);
    endtask

    // compressed byte; the node fields are randomised
    task automatic send_byte(input int data);
        t_in_item w;
        w.kind            = KIND_BYTE;
        w.node_index      = IDX_W'($urandom_range(NODE_COUNT - 1));
        w.node_is_leaf    = 1'($urandom_range(1));
        w.node_zero_child = IDX_W'($urandom_range(NODE_COUNT - 1));
        w.node_one_child  = IDX_W'($urandom_range(NODE_COUNT - 1));
        w.node_symbol     = SYM_W'($urandom_range(255));
        w.data_byte       = 8'(data);
        send_word(w);
    endtask

    // let everything drain before touching a register
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_reg(idx, val);
        @(posedge clk);
    endtask

    // a child that is already in the table, or the node itself
    function automatic int pick_child(input int self_idx);
        if (loaded_nodes.size() == 0 || $urandom_range(3) == 0)
            return self_idx;
        return loaded_nodes[$urandom_range(loaded_nodes.size() - 1)];
    endfunction

    // random full binary tree, children always written before parents
    task automatic build_tree(input int n_leaves, output int root, inout int n_sent);
        bit taken [NODE_COUNT];
        int slots [$];
        int pool [$];
        int idx, a, b, j, k;
        for (k = 0; k < 2 * n_leaves - 1; k++) begin
            do idx = $urandom_range(NODE_COUNT - 1); while (taken[idx]);
            taken[idx] = 1'b1;
            slots.push_back(idx);
        end
        for (k = 0; k < n_leaves; k++) begin
            send_node(slots[k], 1'b1, pick_child(slots[k]), pick_child(slots[k]),
                      $urandom_range(255));
            pool.push_back(slots[k]);
            n_sent++;
        end
        for (k = n_leaves; k < 2 * n_leaves - 1; k++) begin
            j = $urandom_range(pool.size() - 1);
            a = pool[j];
            pool.delete(j);
            j = $urandom_range(pool.size() - 1);
            b = pool[j];
            pool.delete(j);
            send_node(slots[k], 1'b0, a, b, $urandom_range(255));
            pool.push_back(slots[k]);
            n_sent++;
        end
        root = pool[0];
    endtask

    // -------------------------------------------------------------------------
    // tests
    // -------------------------------------------------------------------------

    // count is zero after reset: bytes are padding
    task automatic test_reset_padding();
        send_byte(8'hFF);
        send_byte(8'h00);
        wait_idle();
    endtask

    // small fixed tree: 0 -> ff, 10 -> 00, 11 -> a5, root at the top index
    task automatic test_basic_tree();
        send_node(0, 1'b1, 0, 0, 8'hFF);
        send_node(1, 1'b1, 0, 1, 8'h00);
        send_node(2, 1'b1, 1, 0, 8'hA5);
        send_node(3, 1'b0, 1, 2, 8'h5A);
        send_node(511, 1'b0, 0, 3, 8'h00);
        wait_idle();
        write_reg(CFG_ROOT_NODE, 32'd511);
        // count runs out mid-byte, then a whole padding byte
        write_reg(CFG_SYMBOL_COUNT, 32'd5);
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_idle();
        write_reg(CFG_SYMBOL_COUNT, 32'hFFFF_FFFF);
        send_byte(8'hFF);
        send_byte(8'hB6);
        // code split across bytes, then eight symbols from one byte
        send_byte(8'h55);
        send_byte(8'h80);
        wait_idle();
    endtask

    // root moved mid-code; leaf root whose children are still followed
    task automatic test_root_change();
        send_byte(8'h01);
        send_node(300, 1'b1, 0, 511, 8'h3C);
        wait_idle();
        write_reg(CFG_ROOT_NODE, 32'd300);
        send_byte(8'h9F);
        wait_idle();
        write_reg(CFG_ROOT_NODE, 32'd0);
        write_reg(CFG_SYMBOL_COUNT, 32'd3);
        send_byte(8'h5A);
        wait_idle();
    endtask

    // zero count decodes nothing; count of one flags both ends
    task automatic test_count_edges();
        write_reg(CFG_ROOT_NODE, 32'd511);
        write_reg(CFG_SYMBOL_COUNT, 32'd0);
        send_byte(8'hC3);
        wait_idle();
        write_reg(CFG_SYMBOL_COUNT, 32'd1);
        send_byte(8'h80);
        send_byte(8'h00);
        wait_idle();
    endtask

    // random trees and bytes, with the odd stray node write
    task automatic test_random_streams(input int n_words);
        int sent, root, n_bytes, k, pick;
        logic [31:0] count;
        sent = 0;
        while (sent < n_words) begin
            build_tree($urandom_range(2, 8), root, sent);
            wait_idle();
            write_reg(CFG_ROOT_NODE, 32'(root));
            // now and then only the root moves
            if ($urandom_range(4) != 0) begin
                pick = $urandom_range(15);
                if (pick == 0)
                    count = $urandom();
                else if (pick == 1)
                    count = 32'd0;
                else
                    count = 32'($urandom_range(1, 40));
                write_reg(CFG_SYMBOL_COUNT, count);
            end
            n_bytes = $urandom_range(4, 16);
            for (k = 0; k < n_bytes; k++) begin
                if ($urandom_range(9) == 0) begin
                    pick = $urandom_range(NODE_COUNT - 1);
                    send_node(pick, 1'($urandom_range(1)), pick_child(pick),
                              pick_child(pick), $urandom_range(255));
                end else begin
                    send_byte($urandom_range(255));
                end
                sent++;
            end
            wait_idle();
        end
    endtask

    // -------------------------------------------------------------------------
    // sequence
    // -------------------------------------------------------------------------
    initial begin
        tx_idle_pct = 29;
        rx_idle_pct = 53;
        foreach (node_loaded[i])
            node_loaded[i] = 1'b0;
        walk_node    = '0;
        root_reg     = '0;
        symbols_left = '0;

        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_padding();
        test_basic_tree();
        test_root_change();
        test_count_edges();
        test_random_streams(55);

        tx_idle_pct = 53;
        rx_idle_pct = 29;
        test_random_streams(55);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_streams(55);

        wait_idle();
        if (mismatch_count == 0 && pending_symbols.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/htbd_pkg.sv
hw/rtl/htbd_ram.sv
hw/rtl/htbd_ctrl.sv
hw/rtl/htbd_datapath.sv
hw/rtl/huffman_tree_bit_decoder.sv
verif/tb_huffman_tree_bit_decoder.sv
